@@ rtl/pva_pkg.sv @@
// Shared types, codes and the key code helper for the voice allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package pva_pkg;

  localparam int unsigned MASK_W  = 8;
  localparam int unsigned VOICE_W = 3;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_CLEAR    = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the input beat and restart the scan
    logic step;    // examine one voice
    logic commit;  // update voice state and load the result register
  } pva_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;  // the voice under examination is the last one
  } pva_status_t;

  function automatic logic [3:0] note_code(input logic [3:0] semi);
    logic [3:0] code;
    case (semi)
      4'd0:    code = 4'd0;
      4'd1:    code = 4'd1;
      4'd2:    code = 4'd2;
      4'd3:    code = 4'd4;
      4'd4:    code = 4'd5;
      4'd5:    code = 4'd6;
      4'd6:    code = 4'd8;
      4'd7:    code = 4'd9;
      4'd8:    code = 4'd10;
      4'd9:    code = 4'd12;
      4'd10:   code = 4'd13;
      4'd11:   code = 4'd14;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

  // Octave from note / 12 minus one, clamped to 0..7, above the note code.
  // The quotient uses n * 43 >> 9, which is exact for every 7-bit note.
  function automatic logic [NOTE_W-1:0] key_code(input logic [NOTE_W-1:0] note);
    logic [12:0] prod;
    logic [3:0]  quot;
    logic [6:0]  times12;
    logic [3:0]  semi;
    logic [2:0]  oct;
    prod    = 13'(note) * 13'd43;
    quot    = prod[12:9];
    times12 = 7'(quot) * 7'd12;
    semi    = 4'(note - times12);
    if (quot == 4'd0) begin
      oct = 3'd0;
    end else if (quot > 4'd8) begin
      oct = 3'd7;
    end else begin
      oct = 3'(quot - 4'd1);
    end
    return {oct, note_code(semi)};
  endfunction

endpackage

`default_nettype wire

@@ rtl/pva_ctrl.sv @@
// Sequencer for the voice allocator: accept a beat, scan the voices, commit.
// Depends on pva_pkg; drives pva_datapath through pva_cmd_t.
`default_nettype none

module pva_ctrl
  import pva_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output pva_cmd_t   cmd_o,
  input  pva_status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
      end
      ST_COMMIT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/pva_datapath.sv @@
// Voice state, one-voice-per-cycle scan trackers and the result register.
// Depends on pva_pkg; sequenced by pva_ctrl.
`default_nettype none

module pva_datapath
  import pva_pkg::*;
#(
  parameter int unsigned VOICES   = 8,
  parameter int unsigned AGE_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_wr_en_i,
  input  wire logic [MASK_W-1:0]   cfg_wr_data_i,
  input  wire logic [OP_W-1:0]     op_i,
  input  wire logic [NOTE_W-1:0]   note_i,
  input  pva_cmd_t                 cmd_i,
  output pva_status_t              status_o,
  output logic                     accepted_o,
  output logic [VOICE_W-1:0]       voice_o,
  output logic [NOTE_W-1:0]        key_code_o,
  output logic [MASK_W-1:0]        released_mask_o,
  output logic [MASK_W-1:0]        key_on_mask_o
);

  localparam int unsigned IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

  logic [MASK_W-1:0]   en_mask_q;
  logic [VOICES-1:0]   valid_q, valid_d;
  logic [NOTE_W-1:0]   note_q [VOICES];
  logic [AGE_BITS-1:0] age_q  [VOICES];
  logic [AGE_BITS-1:0] age_cnt_q, age_cnt_d;
  logic [VOICES-1:0]   keyed_q, keyed_d;

  logic [OP_W-1:0]     op_q;
  logic [NOTE_W-1:0]   note_in_q;
  logic [IDX_W-1:0]    idx_q;
  logic [VOICES-1:0]   released_q;

  logic                hit_found_q, free_found_q, old_found_q;
  logic [IDX_W-1:0]    hit_idx_q, free_idx_q, old_idx_q;
  logic [AGE_BITS-1:0] old_age_q;

  logic                cur_en, cur_valid, cur_match;
  logic [AGE_BITS-1:0] cur_age;
  logic                pick_ok;
  logic [IDX_W-1:0]    pick;
  logic                do_alloc;
  logic [MASK_W-1:0]   released_out;

  assign cur_en    = en_mask_q[idx_q];
  assign cur_valid = valid_q[idx_q];
  assign cur_match = (note_q[idx_q] == note_in_q);
  assign cur_age   = age_q[idx_q];

  assign status_o.scan_last = (idx_q == LAST_IDX);

  // Same note first, then lowest free voice, then oldest stamp.
  always_comb begin
    pick_ok = hit_found_q || free_found_q || old_found_q;
    if (hit_found_q) begin
      pick = hit_idx_q;
    end else if (free_found_q) begin
      pick = free_idx_q;
    end else begin
      pick = old_idx_q;
    end
  end

  assign do_alloc = cmd_i.commit && (op_q == OP_NOTE_ON) && pick_ok;

  always_comb begin
    valid_d      = valid_q;
    keyed_d      = keyed_q;
    age_cnt_d    = age_cnt_q;
    released_out = '0;
    // A note-off frees holders while the scan passes over them.
    if (cmd_i.step && (op_q == OP_NOTE_OFF) && cur_valid && cur_match) begin
      valid_d[idx_q] = 1'b0;
    end
    if (cmd_i.commit) begin
      case (op_q)
        OP_NOTE_ON: begin
          if (pick_ok) begin
            valid_d[pick] = 1'b1;
            keyed_d[pick] = 1'b1;
            age_cnt_d     = age_cnt_q + AGE_BITS'(1);
          end
        end
        OP_NOTE_OFF: begin
          keyed_d      = keyed_q & ~released_q;
          released_out = MASK_W'(released_q);
        end
        OP_CLEAR: begin
          valid_d      = '0;
          keyed_d      = '0;
          age_cnt_d    = '0;
          released_out = MASK_W'({VOICES{1'b1}});
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_mask_q <= '1;
      valid_q   <= '0;
      keyed_q   <= '0;
      age_cnt_q <= '0;
    end else begin
      if (cfg_wr_en_i) en_mask_q <= cfg_wr_data_i;
      valid_q   <= valid_d;
      keyed_q   <= keyed_d;
      age_cnt_q <= age_cnt_d;
    end
  end

  // Notes are only used for voices whose valid bit is set; stamps are compared for every enabled voice.
  always_ff @(posedge clk_i) begin
    if (do_alloc) begin
      note_q[pick] <= note_in_q;
      age_q[pick]  <= age_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.step && !status_o.scan_last) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= op_i;
      note_in_q    <= note_i;
      released_q   <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      old_found_q  <= 1'b0;
    end else if (cmd_i.step) begin
      if (cur_valid && cur_match) begin
        released_q[idx_q] <= 1'b1;
      end
      if (cur_en && cur_valid && cur_match && !hit_found_q) begin
        hit_found_q <= 1'b1;
        hit_idx_q   <= idx_q;
      end
      if (cur_en && !cur_valid && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= idx_q;
      end
      if (cur_en && (!old_found_q || (cur_age < old_age_q))) begin
        old_found_q <= 1'b1;
        old_idx_q   <= idx_q;
        old_age_q   <= cur_age;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      accepted_o      <= do_alloc;
      voice_o         <= do_alloc ? VOICE_W'(pick) : '0;
      key_code_o      <= do_alloc ? key_code(note_in_q) : '0;
      released_mask_o <= released_out;
      key_on_mask_o   <= MASK_W'(keyed_d);
    end
  end

endmodule

`default_nettype wire

@@ rtl/poly_voice_allocator.sv @@
// Top level of the polyphonic voice allocator.
// Depends on pva_pkg, pva_ctrl and pva_datapath.
`default_nettype none

// Each beat is accepted in ST_IDLE; ST_SCAN then visits each voice in turn,
// comparing the note, finding the lowest free voice and tracking the oldest
// stamp; ST_COMMIT commits the choice and loads the result register once
// it is free. The next beat is accepted as soon as the commit is
// done, even while the previous result still waits on the output side.
// Opcode travels in s_axis_tuser; the accepted flag in m_axis_tuser.
module poly_voice_allocator
  import pva_pkg::*;
#(
  parameter int unsigned VOICES   = 8,
  parameter int unsigned AGE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [7:0]  cfg_wr_data_i,   // voice_enable_mask
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,    // [6:0] note, [7] zero
  input  wire logic [1:0]  s_axis_tuser,    // [1:0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,    // [2:0] voice, [9:3] key_code,
                                            // [17:10] released_mask,
                                            // [25:18] key_on_mask, rest zero
  output logic [0:0]       m_axis_tuser     // [0] accepted
);

  pva_cmd_t           cmd;
  pva_status_t        status;
  logic               accepted;
  logic [VOICE_W-1:0] voice;
  logic [NOTE_W-1:0]  key_code_w;
  logic [MASK_W-1:0]  released_mask;
  logic [MASK_W-1:0]  key_on_mask;

  pva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  pva_datapath #(
    .VOICES   (VOICES),
    .AGE_BITS (AGE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .op_i            (s_axis_tuser),
    .note_i          (s_axis_tdata[NOTE_W-1:0]),
    .cmd_i           (cmd),
    .status_o        (status),
    .accepted_o      (accepted),
    .voice_o         (voice),
    .key_code_o      (key_code_w),
    .released_mask_o (released_mask),
    .key_on_mask_o   (key_on_mask)
  );

  assign m_axis_tdata = {6'd0, key_on_mask, released_mask, key_code_w, voice};
  assign m_axis_tuser = accepted;

endmodule

`default_nettype wire
